// ===== design/pws_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_pkg
// shared constants, types and the pitch bend factor rom for the wavetable synth
// ----------------------------------------------------------------------------
package pws_pkg;

   localparam int VOICE_COUNT     = 15;
   localparam int VOICE_AW        = 4;
   localparam int WAVE_LEN        = 1024;
   localparam int WAVE_AW         = 10;
   localparam int PHASE_FRAC_BITS = 16;
   localparam int PHASE_W         = 26;
   localparam int STEP_W          = 27;
   localparam int STEP_TBL_W      = 26;
   localparam int KEY_COUNT       = 128;
   localparam int KEY_W           = 7;
   localparam int FACTOR_W        = 17;
   localparam int BEND_PROD_W     = STEP_TBL_W + FACTOR_W;
   localparam int SAMPLE_W        = 16;
   localparam int VOL_W           = 7;
   localparam int MIX_PROD_W      = SAMPLE_W + VOL_W + 1;
   localparam int SUM_W           = 24;
   localparam int DAC_W           = 12;
   localparam int DAC_MID         = 2048;
   localparam int DAC_MAX         = 4095;

   localparam logic [2:0] MODE_TICK      = 3'd0;
   localparam logic [2:0] MODE_NOTE_ON   = 3'd1;
   localparam logic [2:0] MODE_NOTE_OFF  = 3'd2;
   localparam logic [2:0] MODE_BEND      = 3'd3;
   localparam logic [2:0] MODE_LOAD_WAVE = 3'd4;
   localparam logic [2:0] MODE_LOAD_STEP = 3'd5;

   typedef struct packed {
      logic                  active;
      logic [KEY_W-1:0]      note;
      logic [3:0]            chan;
      logic [VOL_W-1:0]      volume;
      logic [STEP_W-1:0]     step;
      logic [PHASE_W-1:0]    phase;
   } voice_type;

   typedef struct packed {
      logic clear;
      logic mul;
      logic acc;
   } mix_ctl_type;

   localparam logic [FACTOR_W-1:0] BEND_FACTOR [0:63] = '{
      17'd61858, 17'd61970, 17'd62081, 17'd62194, 17'd62306, 17'd62419, 17'd62531, 17'd62644,
      17'd62757, 17'd62871, 17'd62984, 17'd63098, 17'd63212, 17'd63326, 17'd63441, 17'd63556,
      17'd63670, 17'd63785, 17'd63901, 17'd64016, 17'd64132, 17'd64248, 17'd64364, 17'd64480,
      17'd64596, 17'd64713, 17'd64830, 17'd64947, 17'd65065, 17'd65182, 17'd65300, 17'd65418,
      17'd65536, 17'd65654, 17'd65773, 17'd65892, 17'd66011, 17'd66130, 17'd66250, 17'd66369,
      17'd66489, 17'd66609, 17'd66730, 17'd66850, 17'd66971, 17'd67092, 17'd67213, 17'd67335,
      17'd67456, 17'd67578, 17'd67700, 17'd67823, 17'd67945, 17'd68068, 17'd68191, 17'd68314,
      17'd68438, 17'd68561, 17'd68685, 17'd68809, 17'd68933, 17'd69058, 17'd69183, 17'd69308
   };

endpackage
`default_nettype wire

// ===== design/pws_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== design/pws_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pws_mixer
// scales voice samples by volume, accumulates them and saturates the dac sample
// ----------------------------------------------------------------------------
module pws_mixer
   import pws_pkg::*;
(
   input  wire logic                        clock,
   input  wire mix_ctl_type                 ctl,
   input  wire logic signed [SAMPLE_W-1:0]  sample,
   input  wire logic [VOL_W-1:0]            volume,
   output logic [DAC_W-1:0]                 dac
);

   logic signed [MIX_PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic signed [SUM_W-1:0]      term;
   logic signed [SUM_W-1:0]      scaled;
   logic signed [SUM_W-1:0]      biased;

   // arithmetic shifts give floor division
   assign term   = SUM_W'(prod_ff >>> 4);
   assign scaled = sum_ff >>> 10;
   assign biased = scaled + SUM_W'(DAC_MID);

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= MIX_PROD_W'(sample * $signed({1'b0, volume}));
      end
      if (ctl.clear) begin
         sum_ff <= '0;
      end else if (ctl.acc) begin
         sum_ff <= sum_ff + term;
      end
   end

   always_comb begin
      priority if (biased < 0) begin
         dac = '0;
      end else if (biased > SUM_W'(DAC_MAX)) begin
         dac = DAC_W'(DAC_MAX);
      end else begin
         dac = biased[DAC_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== design/polyphonic_wavetable_synth_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth_top
// fifteen voice wavetable synth: voice state, wave table and step table in ram
// ----------------------------------------------------------------------------
//  channel   direction  ports
//  req       in         req_valid/req_ready, mode channel key velocity bend
//                       wave_index wave_value step_value
//  rsp       out        rsp_valid/rsp_ready, dac_sample (tick requests only)
//
//  one request at a time; the sequencer visits voices one by one through the
//  single read port of the voice ram.
//  tick: each voice is read and evaluated; an active one also reads the wave
//  and accumulates, then the sample is emitted. note on/off: step lookup, then
//  voices until a match. bend: every voice; a match adds step read and write.
//  reset clears the voice ram through per-entry valid bits; no clearing pass.
//  a held result stalls only the next tick at its final cycle.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_synth_top
   import pws_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [2:0]               req_mode,
   input  wire logic [3:0]               req_channel,
   input  wire logic [6:0]               req_key,
   input  wire logic [6:0]               req_velocity,
   input  wire logic [13:0]              req_bend,
   input  wire logic [9:0]               req_wave_index,
   input  wire logic signed [15:0]       req_wave_value,
   input  wire logic [25:0]              req_step_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [11:0]                   rsp_dac_sample
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_KEY  = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_VO   = 4'd3;
   localparam logic [3:0] S_WV   = 4'd4;
   localparam logic [3:0] S_AC   = 4'd5;
   localparam logic [3:0] S_SR   = 4'd6;
   localparam logic [3:0] S_BW   = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   localparam int VOICE_W = $bits(voice_type);

   logic [3:0]              state_ff, state_in;
   logic [VOICE_AW-1:0]     vidx_ff, vidx_in;
   logic [2:0]              op_ff;
   logic [3:0]              chan_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [VOL_W-1:0]        vel_ff;
   logic [5:0]              bsel_ff;
   logic [STEP_TBL_W-1:0]   stepk_ff;
   voice_type               vdat_ff;
   logic [BEND_PROD_W-1:0]  bprod_ff;
   logic [VOICE_COUNT-1:0]  vvalid_ff;
   logic                    rsp_valid_ff;
   logic [DAC_W-1:0]        rsp_data_ff;

   logic                    accept;
   logic                    last_voice;
   voice_type               vcur;
   voice_type               vram_q;
   logic [VOICE_W-1:0]      vram_q_raw;
   logic                    vwr_en;
   voice_type               vwr_data;
   logic [STEP_TBL_W-1:0]   step_q;
   logic [KEY_W-1:0]        step_raddr;
   logic                    wave_we;
   logic [WAVE_AW-1:0]      wave_raddr;
   logic signed [SAMPLE_W-1:0] wave_q;
   logic [PHASE_W:0]        phase_sum;
   logic [PHASE_W-1:0]      phase_new;
   mix_ctl_type             mix_ctl;
   logic [DAC_W-1:0]        mix_dac;

   assign req_ready      = (state_ff == S_IDLE);
   assign accept         = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dac_sample = rsp_data_ff;
   assign last_voice     = (vidx_ff == VOICE_AW'(VOICE_COUNT - 1));

   // an entry never written since reset reads as an idle zeroed voice
   assign vram_q = voice_type'(vram_q_raw);
   assign vcur   = vvalid_ff[vidx_ff] ? vram_q : '0;

   // table length is a power of two, so the wrap is a mask
   assign phase_sum  = (PHASE_W + 1)'(vcur.phase) + (PHASE_W + 1)'(vcur.step);
   assign phase_new  = phase_sum[PHASE_W-1:0];
   assign wave_raddr = phase_new[PHASE_W-1:PHASE_FRAC_BITS];

   assign step_raddr = (state_ff == S_IDLE) ? req_key : vcur.note;
   assign wave_we    = accept && (req_mode == MODE_LOAD_WAVE)
                       && (32'(req_wave_index) < WAVE_LEN);

   always_comb begin
      state_in       = state_ff;
      vidx_in        = vidx_ff;
      vwr_en         = 1'b0;
      vwr_data       = vcur;
      mix_ctl        = '0;
      unique case (state_ff)
         S_IDLE: begin
            vidx_in = '0;
            if (accept) begin
               mix_ctl.clear = (req_mode == MODE_TICK);
               priority if (req_mode == MODE_TICK || req_mode == MODE_BEND) begin
                  state_in = S_RD;
               end else if (req_mode == MODE_NOTE_ON || req_mode == MODE_NOTE_OFF) begin
                  state_in = S_KEY;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_KEY: begin
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_VO;
         end
         S_VO: begin
            state_in = S_RD;
            if (last_voice) begin
               state_in = (op_ff == MODE_TICK) ? S_OUT : S_IDLE;
            end else begin
               vidx_in = vidx_ff + 1'b1;
            end
            unique case (op_ff)
               MODE_TICK: begin
                  if (vcur.active) begin
                     vwr_en         = 1'b1;
                     vwr_data.phase = phase_new;
                     state_in       = S_WV;
                     vidx_in        = vidx_ff;
                  end
               end
               MODE_NOTE_ON: begin
                  if (!vcur.active) begin
                     vwr_en          = 1'b1;
                     vwr_data.active = 1'b1;
                     vwr_data.note   = key_ff;
                     vwr_data.chan   = chan_ff;
                     vwr_data.volume = vel_ff;
                     vwr_data.step   = STEP_W'(stepk_ff);
                     vwr_data.phase  = '0;
                     state_in        = S_IDLE;
                  end
               end
               MODE_NOTE_OFF: begin
                  if (vcur.active && vcur.note == key_ff) begin
                     vwr_en          = 1'b1;
                     vwr_data.active = 1'b0;
                     vwr_data.chan   = '0;
                     vwr_data.step   = STEP_W'(stepk_ff);
                     state_in        = S_IDLE;
                  end
               end
               default: begin
                  if (vcur.active && vcur.chan == chan_ff) begin
                     state_in = S_SR;
                     vidx_in  = vidx_ff;
                  end
               end
            endcase
         end
         S_WV: begin
            mix_ctl.mul = 1'b1;
            state_in    = S_AC;
         end
         S_AC: begin
            mix_ctl.acc = 1'b1;
            if (last_voice) begin
               state_in = S_OUT;
            end else begin
               state_in = S_RD;
               vidx_in  = vidx_ff + 1'b1;
            end
         end
         S_SR: begin
            state_in = S_BW;
         end
         S_BW: begin
            vwr_en        = 1'b1;
            vwr_data      = vdat_ff;
            vwr_data.step = bprod_ff[BEND_PROD_W-1 -: STEP_W];
            if (last_voice) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_RD;
               vidx_in  = vidx_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vidx_ff      <= '0;
         vvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vidx_ff  <= vidx_in;
         if (vwr_en) begin
            vvalid_ff[vidx_ff] <= 1'b1;
         end
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         // note on with zero velocity is a note off
         op_ff   <= (req_mode == MODE_NOTE_ON && req_velocity == '0) ? MODE_NOTE_OFF
                                                                      : req_mode;
         chan_ff <= req_channel;
         key_ff  <= req_key;
         vel_ff  <= req_velocity;
         bsel_ff <= req_bend[13:8];
      end
      if (state_ff == S_KEY) begin
         stepk_ff <= step_q;
      end
      if (state_ff == S_VO) begin
         vdat_ff <= vcur;
      end
      if (state_ff == S_SR) begin
         bprod_ff <= BEND_PROD_W'(step_q * BEND_FACTOR[bsel_ff]);
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff <= mix_dac;
      end
   end

   pws_ram #(
      .WIDTH (VOICE_W),
      .DEPTH (VOICE_COUNT)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (vwr_en),
      .wr_addr (vidx_ff),
      .wr_data (VOICE_W'(vwr_data)),
      .rd_addr (vidx_ff),
      .rd_data (vram_q_raw)
   );

   pws_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WAVE_LEN)
   ) u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_we),
      .wr_addr (req_wave_index),
      .wr_data (req_wave_value),
      .rd_addr (wave_raddr),
      .rd_data (wave_q)
   );

   pws_ram #(
      .WIDTH (STEP_TBL_W),
      .DEPTH (KEY_COUNT)
   ) u_step_ram (
      .clock   (clock),
      .wr_en   (accept && req_mode == MODE_LOAD_STEP),
      .wr_addr (req_key),
      .wr_data (req_step_value),
      .rd_addr (step_raddr),
      .rd_data (step_q)
   );

   pws_mixer u_mixer (
      .clock  (clock),
      .ctl    (mix_ctl),
      .sample (wave_q),
      .volume (vdat_ff.volume),
      .dac    (mix_dac)
   );

   // a result appears only after the final mixing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output step");

   // the voice index never walks past the pool
   assert property (@(posedge clock) disable iff (reset)
      vidx_ff <= VOICE_AW'(VOICE_COUNT - 1))
      else $error("voice index out of range");

   // voice ram is written only while evaluating or after a bend
   assert property (@(posedge clock) disable iff (reset)
      vwr_en |-> (state_ff == S_VO || state_ff == S_BW))
      else $error("voice write in wrong step");

   // a pending result is never overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_dac_sample)))
      else $error("pending result lost");

endmodule
`default_nettype wire
